[design/fdn_pkg.sv]
// ----------------------------------------------------------------------------
// fdn_pkg: shared types, constants and helpers of the FDN reverb
// Payload structs, register indexes, the sequencer states and the saturation
// functions used by the line unit and the top level.
// ----------------------------------------------------------------------------
package fdn_pkg;

  // Word widths
  localparam int DATA_W     = 24;  // delay-line word and filter value, Q9.15
  localparam int SAMPLE_W   = 16;  // audio sample, Q1.15
  localparam int LANE_W     = 16;  // one line's lane in the packed registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_W      = 28;  // biased numerator of the line average

  // Default geometry
  localparam int ORDER_DEFAULT     = 4;
  localparam int MAX_DELAY_DEFAULT = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_DELAYS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_DAMPINGS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN      = 3'd4;

  // Register reset values
  localparam logic [15:0] FEEDBACK_GAIN_RESET = 16'd16384;  // 1.0 in Q2.14
  localparam logic [15:0] WET_MIX_RESET       = 16'd0;
  localparam logic [15:0] OUT_GAIN_RESET      = 16'd4096;   // 1.0 in Q4.12
  localparam logic [15:0] WET_FULL            = 16'd32768;  // fully wet

  // Input request
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } in_t;

  // Result request
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic signed [DATA_W-1:0]   reverb_out;
    logic                       last_out;
  } out_t;

  // Sequencer to line unit
  typedef struct packed {
    logic start;   // begin the per-line filter pass
    logic wr_en;   // write one row of the delay store
  } line_ctrl_t;

  // Line unit to sequencer
  typedef struct packed {
    logic             done;  // last line's filter lands this cycle
    logic [NUM_W-1:0] num;   // biased 2*sum + ORDER
  } line_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINES,
    ST_AVG_DIV,
    ST_AVG_SAT,
    ST_SCALE,
    ST_STORE,
    ST_GAIN,
    ST_ROUND
  } state_t;

  // Clamp to a signed 24-bit word
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [63:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[DATA_W-1:0];
  endfunction

  // Clamp to a signed 16-bit sample
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

[design/fdn_reverb.sv]
// ----------------------------------------------------------------------------
// fdn_reverb: feedback delay network reverberator
// Per sample: damping filter on each line's tap, line average, feedback write
// into every line, wet/dry mix and output gain with saturation.
// ----------------------------------------------------------------------------
//
//  channel  signals                                   direction  carries
//  -------  ----------------------------------------  ---------  -----------------
//  item     item_valid, item_stall, item              in         sample, last mark
//  result   result_valid, result_stall, result        out        mix, reverb, last
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data in         register writes
//
//  A sample is accepted only in the idle state. It streams line after line
//  through the filter pipe of the line unit, then through the tail of average,
//  feedback, mix and gain multiplies, before the next sample is accepted.
//  After reset the delay store is cleared one row per cycle, every row of it,
//  with item_stall high; configuration writes are taken throughout.
//  The result sits in an output register: a stalled result does not block the
//  next sample, which only waits for that register at its final cycle.
//
module fdn_reverb #(
  parameter int ORDER     = fdn_pkg::ORDER_DEFAULT,
  parameter int MAX_DELAY = fdn_pkg::MAX_DELAY_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  fdn_pkg::in_t                   item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output fdn_pkg::out_t                  result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdn_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DELAY);
  localparam int ROW_W  = ORDER * DATA_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DELAY - 1);

  // Average: floor(num / 2*ORDER) - bias, by reciprocal multiply
  localparam int     DIV_D   = 2 * ORDER;
  localparam longint BIAS_K  = ((longint'(1) <<< 26) + longint'(DIV_D) - 1) / longint'(DIV_D);
  localparam int     AVG_SH  = 31;
  localparam longint AVG_MUL = ((longint'(1) <<< AVG_SH) + longint'(DIV_D) - 1)
                               / longint'(DIV_D);
  localparam int     AVG_P_W = NUM_W + AVG_SH;

  localparam int FB_W  = DATA_W + 17;
  localparam int WD_W  = DATA_W + 18;
  localparam int MIX_W = 40;
  localparam int GH_W  = MIX_W - 16 + 17;
  localparam int TOT_W = 58;

  // Configuration registers
  logic [CFG_DATA_W-1:0] line_delays;
  logic [CFG_DATA_W-1:0] line_dampings;
  logic [15:0]           feedback_gain;
  logic [15:0]           wet_mix;
  logic [15:0]           out_gain;

  // Sequencer
  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] wp;
  logic              accept;
  logic              out_free;

  // Sample datapath
  logic signed [SAMPLE_W-1:0] x;
  logic                       last;
  logic [AVG_P_W-1:0]         avg_prod;
  logic signed [DATA_W-1:0]   avg;
  logic signed [FB_W-1:0]     fb_prod;
  logic signed [WD_W-1:0]     wd_prod;
  logic signed [MIX_W-1:0]    mix;
  logic signed [GH_W-1:0]     gp_hi;
  logic [31:0]                gp_lo;

  // Line unit link
  line_ctrl_t        ctrl;
  line_stat_t        stat;
  logic [ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  filt_vec;

  // Combinational helpers
  logic [NUM_W-1:0]           avg_q;
  logic signed [NUM_W:0]      avg_full;
  logic [15:0]                w_eff;
  logic signed [DATA_W:0]     dx;
  logic signed [FB_W-1:0]     fb_round;
  logic signed [TOT_W-1:0]    total;
  logic signed [TOT_W-1:0]    y_round;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_delays   <= '0;
      line_dampings <= '0;
      feedback_gain <= FEEDBACK_GAIN_RESET;
      wet_mix       <= WET_MIX_RESET;
      out_gain      <= OUT_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_DELAYS:   line_delays   <= cfg_data;
        CFG_LINE_DAMPINGS: line_dampings <= cfg_data;
        CFG_FEEDBACK_GAIN: feedback_gain <= cfg_data[15:0];
        CFG_WET_MIX:       wet_mix       <= cfg_data[15:0];
        CFG_OUT_GAIN:      out_gain      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and line unit controls
  always_comb begin
    state_next = state;
    ctrl.start = 1'b0;
    ctrl.wr_en = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ctrl.wr_en = 1'b1;
        if (clr_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          ctrl.start = 1'b1;
          state_next = ST_LINES;
        end
      end
      ST_LINES: begin
        if (stat.done) begin
          state_next = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: state_next = ST_AVG_SAT;
      ST_AVG_SAT: state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_STORE;
      ST_STORE: begin
        ctrl.wr_en = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN:    state_next = ST_ROUND;
      ST_ROUND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Clear sweep and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      wp      <= LAST_ADDR;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (state == ST_STORE) begin
        wp <= (wp == '0) ? LAST_ADDR : wp - ADDR_W'(1);
      end
    end
  end

  // Average, feedback and mix arithmetic
  assign avg_q    = avg_prod[AVG_SH +: NUM_W];
  assign avg_full = $signed({1'b0, avg_q}) - (NUM_W + 1)'(BIAS_K);
  assign w_eff    = (wet_mix > WET_FULL) ? WET_FULL : wet_mix;
  assign dx       = (DATA_W + 1)'(avg) - (DATA_W + 1)'(x);
  assign fb_round = (fb_prod + FB_W'(8192)) >>> 14;
  assign total    = (TOT_W'(gp_hi) <<< 16) + $signed({(TOT_W - 32)'(0), gp_lo})
                    + TOT_W'(67108864);
  assign y_round  = total >>> 27;

  // New row: input plus feedback minus each line's filter
  for (genvar k = 0; k < ORDER; k++) begin : g_row
    logic signed [DATA_W+4:0] lane_sum;
    assign lane_sum = (DATA_W + 5)'(x) + (DATA_W + 5)'(fb_round)
                      - (DATA_W + 5)'($signed(filt_vec[k*DATA_W +: DATA_W]));
    assign row[k*DATA_W +: DATA_W] = sat_data(64'(lane_sum));
  end

  assign wr_addr = (state == ST_CLEAR) ? clr_cnt : wp;
  assign wr_data = (state == ST_CLEAR) ? '0 : row;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x    <= item.sample_in;
      last <= item.last_in;
    end
    if (state == ST_AVG_DIV) begin
      avg_prod <= AVG_P_W'(stat.num) * AVG_P_W'(AVG_MUL);
    end
    if (state == ST_AVG_SAT) begin
      avg <= sat_data(64'(avg_full));
    end
    if (state == ST_SCALE) begin
      fb_prod <= $signed({1'b0, feedback_gain}) * avg;
      wd_prod <= $signed({1'b0, w_eff}) * dx;
    end
    if (state == ST_STORE) begin
      mix <= (MIX_W'(x) <<< 15) + MIX_W'(wd_prod);
    end
    if (state == ST_GAIN) begin
      gp_hi <= $signed(mix[MIX_W-1:16]) * $signed({1'b0, out_gain});
      gp_lo <= mix[15:0] * out_gain;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_ROUND && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND && out_free) begin
      result.sample_out <= sat_sample(64'(y_round));
      result.reverb_out <= avg;
      result.last_out   <= last;
    end
  end

  fdn_line_unit #(
    .ORDER     (ORDER),
    .MAX_DELAY (MAX_DELAY)
  ) u_lines (
    .clk           (clk),
    .rst           (rst),
    .line_delays   (line_delays),
    .line_dampings (line_dampings),
    .ctrl          (ctrl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .wp            (wp),
    .stat          (stat),
    .filt_vec      (filt_vec)
  );

endmodule

[design/fdn_line_unit.sv]
// ----------------------------------------------------------------------------
// fdn_line_unit: delay store and per-line damping filters
// Holds the delay store (one row per write index, one lane per line) and the
// filter registers. On start it streams the lines through a six-stage pipe:
// offset reduction, read address, memory read, difference, multiply, round.
// ----------------------------------------------------------------------------
module fdn_line_unit #(
  parameter int ORDER     = fdn_pkg::ORDER_DEFAULT,
  parameter int MAX_DELAY = fdn_pkg::MAX_DELAY_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [fdn_pkg::CFG_DATA_W-1:0]        line_delays,
  input  logic [fdn_pkg::CFG_DATA_W-1:0]        line_dampings,
  input  fdn_pkg::line_ctrl_t                   ctrl,
  input  logic [$clog2(MAX_DELAY)-1:0]          wr_addr,
  input  logic [ORDER*fdn_pkg::DATA_W-1:0]      wr_data,
  input  logic [$clog2(MAX_DELAY)-1:0]          wp,
  output fdn_pkg::line_stat_t                   stat,
  output logic [ORDER*fdn_pkg::DATA_W-1:0]      filt_vec
);
  import fdn_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DELAY);
  localparam int LINE_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int ROW_W  = ORDER * DATA_W;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ORDER - 1);

  // Offset mod MAX_DELAY by reciprocal multiply, exact for 16-bit offsets
  localparam int     RED_SH  = 33;
  localparam longint RED_MUL = ((longint'(1) <<< RED_SH) + longint'(MAX_DELAY) - 1)
                               / longint'(MAX_DELAY);
  localparam int     MUL_W   = 30;
  localparam int     PROD_W  = LANE_W + MUL_W;
  localparam int     QUO_W   = PROD_W - RED_SH;
  localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(MAX_DELAY);

  // Average numerator bias keeps 2*sum + ORDER non-negative
  localparam int     DIV_D    = 2 * ORDER;
  localparam longint BIAS_K   = ((longint'(1) <<< 26) + longint'(DIV_D) - 1) / longint'(DIV_D);
  localparam logic [NUM_W-1:0] NUM_INIT = NUM_W'(BIAS_K * DIV_D + ORDER);

  localparam int ACC_W = DATA_W + 18;

  // Issue counter
  logic              busy;
  logic [LINE_W-1:0] cnt;

  // Pipe stages
  logic v1, v2, v3, v4, v5, v6;
  logic [LINE_W-1:0] l1, l2, l3, l4, l5, l6;
  logic [PROD_W-1:0] p1;
  logic [LANE_W-1:0] off1;
  logic [ADDR_W-1:0] rem2;
  logic [ADDR_W:0]   asum3;
  logic [ROW_W-1:0]  rdata4;
  logic signed [DATA_W-1:0] s5;
  logic signed [DATA_W:0]   diff5;
  logic signed [ACC_W-1:0]  acc6;

  // State
  logic signed [DATA_W-1:0] filt [ORDER];
  logic [NUM_W-1:0]         num;
  logic [ROW_W-1:0]         mem [MAX_DELAY];

  // Combinational taps
  logic [LANE_W-1:0]        off_sel;
  logic [QUO_W-1:0]         quo;
  logic [31:0]              rem_full;
  logic [ADDR_W:0]          rd_wrap;
  logic [ADDR_W-1:0]        rd_idx;
  logic signed [DATA_W-1:0] s_sel;
  logic [LANE_W-1:0]        damp_sel;
  logic signed [ACC_W-1:0]  damp_prod;
  logic signed [ACC_W-1:0]  f_round;
  logic signed [DATA_W-1:0] f_new;
  logic signed [NUM_W-1:0]  f_twice;

  assign off_sel   = line_delays[LANE_W*cnt +: LANE_W];
  assign quo       = p1[RED_SH +: QUO_W];
  assign rem_full  = 32'(off1) - 32'(quo) * 32'(MAX_DELAY);
  assign rd_wrap   = (asum3 >= DEPTH_X) ? (asum3 - DEPTH_X) : asum3;
  assign rd_idx    = rd_wrap[ADDR_W-1:0];
  assign s_sel     = $signed(rdata4[DATA_W*l4 +: DATA_W]);
  assign damp_sel  = line_dampings[LANE_W*l5 +: LANE_W];
  // D*f + (1-D)*s rewritten as s + D*(f - s)
  assign damp_prod = $signed({1'b0, damp_sel}) * diff5;
  assign f_round   = (acc6 + ACC_W'(32768)) >>> 16;
  assign f_new     = sat_data(64'(f_round));
  assign f_twice   = NUM_W'(f_new) <<< 1;

  // Issue and pipe control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
    end else begin
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        busy <= (cnt != LAST_LINE);
        cnt  <= cnt + LINE_W'(1);
      end
      v1 <= busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Pipe payload
  always_ff @(posedge clk) begin
    l1    <= cnt;
    off1  <= off_sel;
    p1    <= PROD_W'(off_sel) * PROD_W'(RED_MUL);
    l2    <= l1;
    rem2  <= rem_full[ADDR_W-1:0];
    l3    <= l2;
    asum3 <= {1'b0, wp} + {1'b0, rem2};
    l4    <= l3;
    l5    <= l4;
    s5    <= s_sel;
    diff5 <= (DATA_W + 1)'(filt[l4]) - (DATA_W + 1)'(s_sel);
    l6    <= l5;
    acc6  <= (ACC_W'(s5) <<< 16) + damp_prod;
  end

  // Filter update and running numerator
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        filt[k] <= '0;
      end
    end else if (v6) begin
      filt[l6] <= f_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num <= NUM_INIT;
    end else if (v6) begin
      num <= num + NUM_W'(f_twice);
    end
  end

  // Delay store: one row write, one row read per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (v3) begin
      rdata4 <= mem[rd_idx];
    end
  end

  // Status and filter taps
  assign stat.done = v6 && (l6 == LAST_LINE);
  assign stat.num  = num;

  for (genvar k = 0; k < ORDER; k++) begin : g_taps
    assign filt_vec[k*DATA_W +: DATA_W] = filt[k];
  end

endmodule
